FILE: rtl/core/bitparallel_event_sequence_match_top_assert.svh
// ---------------------------------------------------------------------------
// Event sequence matcher assertion macros
// Shared property forms for the matcher's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef BITPARALLEL_EVENT_SEQUENCE_MATCH_TOP_ASSERT_SVH
`define BITPARALLEL_EVENT_SEQUENCE_MATCH_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BESM_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BESM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/besm_pkg.sv
// ---------------------------------------------------------------------------
// Event sequence matcher package
// Item types, chain cell types and fixed constants of the matcher.
// ---------------------------------------------------------------------------
package besm_pkg;

	localparam int MAX_STAGES = 8;
	localparam int WORD_BITS  = 64;
	localparam int STG_W      = $clog2(MAX_STAGES);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int IDX_W      = 26;
	localparam int POS_W      = 32;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	localparam logic [WORD_BITS-1:0] EDGE_CLEAR = 64'h7FFF_FFFF_FFFF_FFFE;

	// register indexes on the configuration port
	localparam logic [1:0] REG_STAGE_COUNT   = 2'd0;
	localparam logic [1:0] REG_NEGATION_MASK = 2'd1;
	localparam logic [1:0] REG_WINDOW_LEN    = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0]     word_index;
		logic [WORD_BITS-1:0] stage_word_0;
		logic [WORD_BITS-1:0] stage_word_1;
		logic [WORD_BITS-1:0] stage_word_2;
		logic [WORD_BITS-1:0] stage_word_3;
		logic [WORD_BITS-1:0] stage_word_4;
		logic [WORD_BITS-1:0] stage_word_5;
		logic [WORD_BITS-1:0] stage_word_6;
		logic [WORD_BITS-1:0] stage_word_7;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             last_match;
	} out_item_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic                 neg;
	} cell_data_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

FILE: rtl/core/besm_cell.sv
// ---------------------------------------------------------------------------
// Event sequence matcher chain cell
// Holds one stage word and its negation flag; takes its lower neighbor's
// contents on every shift.
// ---------------------------------------------------------------------------
module besm_cell (
	input  logic                clk,
	input  besm_pkg::cell_ctrl_t ctrl,
	input  besm_pkg::cell_data_t load_data,
	input  besm_pkg::cell_data_t prev,
	output besm_pkg::cell_data_t data
);
	import besm_pkg::*;

	cell_data_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.shift) begin
			data_q <= prev;
		end
	end

	assign data = data_q;

endmodule

FILE: rtl/core/besm_drain.sv
// ---------------------------------------------------------------------------
// Event sequence matcher drain
// Holds the final match vector and emits one position per cycle, lowest
// set bit first.
// ---------------------------------------------------------------------------
module besm_drain (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [besm_pkg::WORD_BITS-1:0] load_bits,
	input  logic [besm_pkg::IDX_W-1:0]     load_index,
	output logic                         busy,
	output logic                         strobe,
	output besm_pkg::out_item_t          result
);
	import besm_pkg::*;

	logic [WORD_BITS-1:0] rest_q;
	logic [IDX_W-1:0]     idx_q;
	logic [WORD_BITS-1:0] low_bit;
	logic [WORD_BITS-1:0] rest_next;
	logic [BIT_W-1:0]     bit_pos;

	// isolate lowest set bit and encode its place
	assign low_bit   = rest_q & (~rest_q + {{(WORD_BITS-1){1'b0}}, 1'b1});
	assign rest_next = rest_q ^ low_bit;

	always_comb begin
		bit_pos = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (low_bit[b]) begin
				bit_pos = bit_pos | BIT_W'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= '0;
		end else if (load) begin
			rest_q <= load_bits;
		end else begin
			rest_q <= rest_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q <= load_index;
		end
	end

	assign busy              = |rest_q;
	assign strobe            = |rest_q;
	// 63 - bit is the complement of the bit index
	assign result.position   = {idx_q, ~bit_pos};
	assign result.last_match = ~(|rest_next);

endmodule

FILE: rtl/core/bitparallel_event_sequence_match_top.sv
// ---------------------------------------------------------------------------
// Event sequence matcher top level
// Folds per-stage occurrence words through a chain of stage cells with a
// carry-subtract step, then reports each matched bucket position.
// ---------------------------------------------------------------------------
// Channel   Handshake                      Payload
// config    psel/penable/pwrite, pready=1  paddr, pwdata, prdata
// item      start & !busy                  item (in_item_t)
// result    result_strobe, one cycle       result (out_item_t)
//
// An item passes through these steps in order: loading the cell chain,
// seeding the window, folding each remaining stage through the shared fold
// unit, one narrowing step per marked stage (a marked stage folded right
// after a narrowing gets none), and showing each match in the drain.
// Reset clears control and sets the registers to 2, 0 and 1; no clearing pass.
// busy stays high until the last result of the item has been shown.
// ---------------------------------------------------------------------------
module bitparallel_event_sequence_match_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [besm_pkg::ADDR_W-1:0] paddr,
	input  logic [besm_pkg::DATA_W-1:0] pwdata,
	output logic [besm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  besm_pkg::in_item_t          item,
	output logic                        result_strobe,
	output besm_pkg::out_item_t         result
);
	import besm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEED   = 4'b0010,
		ST_FOLD   = 4'b0100,
		ST_NARROW = 4'b1000
	} state_t;

	state_t state_q;

	logic [3:0] stage_count_q;
	logic [7:0] negation_mask_q;
	logic [5:0] window_len_q;

	logic [3:0] cnt_c;
	logic [3:0] off_c;
	logic [5:0] wl_c;

	logic                 accept;
	logic                 drain_busy;
	logic                 drain_load;
	logic [WORD_BITS-1:0] stage_words [MAX_STAGES];
	cell_data_t           cell_in   [MAX_STAGES];
	cell_data_t           cell_out  [MAX_STAGES];
	cell_data_t           cell_prev [MAX_STAGES];
	cell_data_t           head;
	cell_ctrl_t           ctrl;

	logic [WORD_BITS-1:0] cur_q;
	logic [WORD_BITS-1:0] win_q;
	logic [WORD_BITS-1:0] m0_q;
	logic [IDX_W-1:0]     idx_q;
	logic [STG_W-1:0]     rem_q;
	logic                 plain_q;

	logic [WORD_BITS-1:0] seed_win;
	logic [WORD_BITS-1:0] fold_val;
	logic [WORD_BITS-1:0] m0_val;
	logic [WORD_BITS-1:0] m1_val;
	logic                 narrow_go;

	// ---- configuration port ----
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q   <= 4'd2;
			negation_mask_q <= 8'd0;
			window_len_q    <= 6'd1;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_STAGE_COUNT:   stage_count_q   <= pwdata[3:0];
				REG_NEGATION_MASK: negation_mask_q <= pwdata[7:0];
				REG_WINDOW_LEN:    window_len_q    <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_STAGE_COUNT:   prdata = {28'd0, stage_count_q};
			REG_NEGATION_MASK: prdata = {24'd0, negation_mask_q};
			REG_WINDOW_LEN:    prdata = {26'd0, window_len_q};
			default:           prdata = '0;
		endcase
	end

	assign cnt_c = (stage_count_q < 4'd2) ? 4'd2 :
		(stage_count_q > 4'(MAX_STAGES)) ? 4'(MAX_STAGES) : stage_count_q;
	assign off_c = 4'(MAX_STAGES) - cnt_c;
	assign wl_c  = (window_len_q == 6'd0) ? 6'd1 : window_len_q;

	// ---- cell chain: head cell holds the stage being folded ----
	assign accept = start && !busy;

	assign stage_words[0] = item.stage_word_0;
	assign stage_words[1] = item.stage_word_1;
	assign stage_words[2] = item.stage_word_2;
	assign stage_words[3] = item.stage_word_3;
	assign stage_words[4] = item.stage_word_4;
	assign stage_words[5] = item.stage_word_5;
	assign stage_words[6] = item.stage_word_6;
	assign stage_words[7] = item.stage_word_7;

	assign head = cell_out[MAX_STAGES-1];
	assign narrow_go = head.neg && !plain_q;

	always_comb begin
		ctrl.load  = accept;
		ctrl.shift = (state_q == ST_SEED) || (state_q == ST_NARROW) ||
			((state_q == ST_FOLD) && !narrow_go);
	end

	for (genvar j = 0; j < MAX_STAGES; j++) begin : g_cell
		logic [STG_W-1:0] stg;
		logic             present;

		always_comb begin
			present = 4'(j) >= off_c;
			stg     = STG_W'(4'(j) - off_c);
			// stage 0 and the last stage are never negated
			cell_in[j].word = present ? stage_words[stg] : '0;
			cell_in[j].neg  = present && negation_mask_q[stg] && (stg != '0) &&
				((4'(stg) + 4'd2) <= cnt_c);
		end

		if (j == 0) begin : g_first
			assign cell_prev[j] = '0;
		end else begin : g_rest
			assign cell_prev[j] = cell_out[j-1];
		end

		besm_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.load_data (cell_in[j]),
			.prev      (cell_prev[j]),
			.data      (cell_out[j])
		);
	end

	// ---- fold unit ----
	always_comb begin
		seed_win = '0;
		for (int i = 0; i < WORD_BITS - 1; i++) begin
			if (6'(i) < wl_c) begin
				seed_win = seed_win | (head.word << i);
			end
		end
	end

	assign fold_val = head.word & ~((head.word | cur_q) - (cur_q << 1)) & win_q;
	assign m0_val   = ~((head.word | cur_q) - (head.word << 1));
	assign m1_val   = (m0_q & cur_q) - head.word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
			plain_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SEED;
					end
				end
				ST_SEED: begin
					rem_q   <= STG_W'(cnt_c - 4'd1);
					plain_q <= 1'b0;
					state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					if (narrow_go) begin
						state_q <= ST_NARROW;
					end else begin
						rem_q   <= rem_q - STG_W'(1);
						plain_q <= 1'b0;
						if (rem_q == STG_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_NARROW: begin
					// the stage after a narrowing always folds plain
					rem_q   <= rem_q - STG_W'(1);
					plain_q <= 1'b1;
					state_q <= ST_FOLD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= item.word_index;
		end
		case (state_q)
			ST_SEED: begin
				cur_q <= head.word;
				win_q <= seed_win;
			end
			ST_FOLD: begin
				if (narrow_go) begin
					m0_q <= m0_val;
				end else begin
					cur_q <= fold_val;
				end
			end
			ST_NARROW: begin
				win_q <= ((m1_val ^ head.word) | m1_val) & win_q;
			end
			default: ;
		endcase
	end

	assign drain_load = (state_q == ST_FOLD) && !narrow_go && (rem_q == STG_W'(1));

	besm_drain u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (drain_load),
		.load_bits  (fold_val & EDGE_CLEAR),
		.load_index (idx_q),
		.busy       (drain_busy),
		.strobe     (result_strobe),
		.result     (result)
	);

	assign busy = (state_q != ST_IDLE) || drain_busy;

	`include "bitparallel_event_sequence_match_top_assert.svh"

	`BESM_ASSERT_NEXT(a_accept_busy, accept, busy && (state_q == ST_SEED),
		"accepted item did not enter seed step")
	`BESM_ASSERT_IMPLY(a_strobe_idle_fold, result_strobe, state_q == ST_IDLE,
		"result shown while fold unit is active")
	`BESM_ASSERT_NEXT(a_last_ends, result_strobe && result.last_match, !result_strobe,
		"result shown after last match of an item")
	`BESM_ASSERT_IMPLY(a_fold_rem, state_q == ST_FOLD || state_q == ST_NARROW,
		rem_q != '0, "fold step with no stage left")

endmodule

FILE: bench/tb_bitparallel_event_sequence_match_top.sv
// ---------------------------------------------------------------------------
// Event sequence matcher testbench
// Drives occurrence-word items through the command port and sets up the
// pattern through the APB port. Each accepted item is folded by a local
// predictor into the expected match positions. Each strobed result is
// compared with the oldest expected position.
// ---------------------------------------------------------------------------
module tb_bitparallel_event_sequence_match_top;
	timeunit 1ns;
	timeprecision 1ps;

	import besm_pkg::*;

	localparam int RESET_CYCLES = 6;
	localparam int DRAIN_CYCLES = 20;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int MAX_REPORTS  = 200;

	typedef enum int {
		GEN_ZERO,
		GEN_ONES,
		GEN_DENSE,
		GEN_SPARSE,
		GEN_PLANTED
	} gen_kind_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                start;
	logic                busy;
	in_item_t            item;
	logic                result_strobe;
	out_item_t           result;

	// local copy of the pattern registers
	logic [3:0]          stage_count_q;
	logic [7:0]          negation_mask_q;
	logic [5:0]          window_len_q;

	out_item_t           expected_positions[$];
	int                  error_count;
	int                  send_idle_pct;

	bitparallel_event_sequence_match_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_REPORTS) begin
			$display("MISMATCH @%0t: %s", $realtime, msg);
		end
		error_count++;
	endtask

	function automatic logic [63:0] fold_stage(logic [63:0] x, logic [63:0] y,
			logic [63:0] win);
		return x & ~((x | y) - (y << 1)) & win;
	endfunction

	function automatic logic [63:0] narrow_window(logic [63:0] neg, logic [63:0] cur,
			logic [63:0] win);
		logic [63:0] m0;
		logic [63:0] m1;
		m0 = ~((neg | cur) - (neg << 1));
		m1 = (m0 & cur) - neg;
		return ((m1 ^ neg) | m1) & win;
	endfunction

	// fold the item's stage words and queue one position per surviving bit
	function automatic void predict_matches(in_item_t it);
		logic [63:0] w [MAX_STAGES];
		logic [63:0] cur;
		logic [63:0] win;
		logic [63:0] rest;
		int          cnt;
		int          wl;
		int          s;
		int          b;
		out_item_t   r;
		w[0] = it.stage_word_0;
		w[1] = it.stage_word_1;
		w[2] = it.stage_word_2;
		w[3] = it.stage_word_3;
		w[4] = it.stage_word_4;
		w[5] = it.stage_word_5;
		w[6] = it.stage_word_6;
		w[7] = it.stage_word_7;
		cnt = int'(stage_count_q);
		if (cnt < 2) cnt = 2;
		if (cnt > MAX_STAGES) cnt = MAX_STAGES;
		wl = int'(window_len_q);
		if (wl == 0) wl = 1;
		cur = w[cnt-1];
		win = cur;
		for (int i = 1; i < wl; i++) win |= cur << i;
		s = cnt - 2;
		while (s >= 0) begin
			// a negated stage consumes the stage before it as a plain fold
			if (s >= 1 && negation_mask_q[s]) begin
				win = narrow_window(w[s], cur, win);
				cur = fold_stage(w[s-1], cur, win);
				s -= 2;
			end else begin
				cur = fold_stage(w[s], cur, win);
				s--;
			end
		end
		rest = cur & EDGE_CLEAR;
		while (rest != 0) begin
			b = 0;
			while (!rest[b]) b++;
			rest &= rest - 64'd1;
			r.position   = {it.word_index, 6'd0} + 32'(63 - b);
			r.last_match = (rest == 0);
			expected_positions = {expected_positions, r};
		end
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic in_item_t make_item(gen_kind_t kind);
		logic [63:0]      w [MAX_STAGES];
		logic [IDX_W-1:0] idx;
		int               b;
		idx = IDX_W'($urandom);
		for (int s = 0; s < MAX_STAGES; s++) begin
			case (kind)
				GEN_ZERO:  w[s] = '0;
				GEN_ONES:  w[s] = '1;
				GEN_DENSE: w[s] = rand_word();
				default:   w[s] = rand_word() & rand_word() & rand_word();
			endcase
		end
		if (kind == GEN_PLANTED) begin
			// chain of events stepping toward later buckets, stage by stage
			b = $urandom_range(63, 1);
			for (int s = 0; s < MAX_STAGES; s++) begin
				w[s][b] = 1'b1;
				b -= $urandom_range(0, 3);
				if (b < 0) b = 0;
			end
		end
		return {idx, w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
	endfunction

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		predict_matches(it);
	endtask

	// hold off until every expected position has come and the block is idle, or DRAIN_LIMIT is reached
	task automatic wait_idle();
		int n;
		start <= 1'b0;
		n = 0;
		do begin
			@(posedge clk);
			n++;
		end while ((expected_positions.size() != 0 || busy !== 1'b0) && n < DRAIN_LIMIT);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_STAGE_COUNT:   stage_count_q   = value[3:0];
			REG_NEGATION_MASK: negation_mask_q = value[7:0];
			REG_WINDOW_LEN:    window_len_q    = value[5:0];
			default: ;
		endcase
	endtask

	task automatic set_pattern(input int cnt, input int neg, input int wl);
		wait_idle();
		write_register(REG_STAGE_COUNT, DATA_W'(cnt));
		write_register(REG_NEGATION_MASK, DATA_W'(neg));
		write_register(REG_WINDOW_LEN, DATA_W'(wl));
	endtask

	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && result_strobe) begin
			if (expected_positions.size() == 0) begin
				report_mismatch($sformatf("unexpected result position %0d last %0b",
					result.position, result.last_match));
			end else begin
				exp_r = expected_positions.pop_front();
				if (result.position !== exp_r.position)
					report_mismatch($sformatf("position got %0d want %0d",
						result.position, exp_r.position));
				if (result.last_match !== exp_r.last_match)
					report_mismatch($sformatf("last_match got %0b want %0b at position %0d",
						result.last_match, exp_r.last_match, exp_r.position));
			end
		end
	end

	// reset values: two stages, no negation, one-bucket window
	task automatic test_reset_values();
		send_item(make_item(GEN_ZERO));
		send_item(make_item(GEN_ONES));
		send_item(make_item(GEN_PLANTED));
		send_item(make_item(GEN_DENSE));
	endtask

	task automatic test_pattern_edges();
		in_item_t it;
		set_pattern(8, 0, 63);
		send_item(make_item(GEN_ONES));
		send_item({26'd0, {8{64'hAAAA_AAAA_AAAA_AAAA}}});
		send_item({26'h3FF_FFFF, {8{64'h5555_5555_5555_5555}}});
		it = make_item(GEN_PLANTED);
		it.word_index = '1;
		send_item(it);
		// all mask bits set: marked stages back to back, edge bits ignored
		set_pattern(8, 255, 63);
		send_item(make_item(GEN_PLANTED));
		send_item(make_item(GEN_PLANTED));
		send_item(make_item(GEN_DENSE));
		send_item(make_item(GEN_ONES));
		// stage count below range, window zero
		set_pattern(0, 255, 0);
		send_item(make_item(GEN_PLANTED));
		send_item(make_item(GEN_DENSE));
		set_pattern(1, 0, 2);
		send_item(make_item(GEN_PLANTED));
		// stage count above range
		set_pattern(15, 8'h02, 5);
		send_item(make_item(GEN_PLANTED));
		send_item(make_item(GEN_DENSE));
		// single negated middle stage
		set_pattern(3, 8'h02, 4);
		send_item(make_item(GEN_PLANTED));
		send_item(make_item(GEN_SPARSE));
		send_item(make_item(GEN_ZERO));
	endtask

	task automatic run_traffic(input int idle_pct, input int n_items);
		int k;
		send_idle_pct = idle_pct;
		for (int n = 0; n < n_items; n++) begin
			if (n % 20 == 0) begin
				set_pattern($urandom_range(0, 15), $urandom_range(0, 255),
					($urandom_range(1) != 0) ? $urandom_range(1, 8) : $urandom_range(0, 63));
			end
			k = $urandom_range(99);
			if (k < 60)      send_item(make_item(GEN_PLANTED));
			else if (k < 80) send_item(make_item(GEN_SPARSE));
			else if (k < 95) send_item(make_item(GEN_DENSE));
			else if (k < 97) send_item(make_item(GEN_ZERO));
			else             send_item(make_item(GEN_ONES));
		end
	endtask

	task automatic test_random_traffic();
		run_traffic(16, 100);
		run_traffic(63, 100);
		run_traffic(0, 100);
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		start           = 1'b0;
		item            = '0;
		stage_count_q   = 4'd2;
		negation_mask_q = 8'd0;
		window_len_q    = 6'd1;
		error_count     = 0;
		send_idle_pct   = 16;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_pattern_edges();
		test_random_traffic();

		wait_idle();
		if (expected_positions.size() != 0)
			report_mismatch($sformatf("%0d expected positions never came",
				expected_positions.size()));
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
